### sv/ffha_pkg.sv
package ffha_pkg;

   localparam int START_W    = 16;
   localparam int LEN_W      = 17;
   localparam int HEAP_BYTES = 65536;

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_OK      = 3'd0,
      ST_NOFIT   = 3'd1,
      ST_ZERO    = 3'd2,
      ST_UNKNOWN = 3'd3,
      ST_FULL    = 3'd4
   } status_type;

   typedef struct packed {
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   len;
   } entry_type;

endpackage

### sv/ffha_req_if.sv
interface ffha_req_if;
   import ffha_pkg::*;

   logic                 valid;
   logic                 ready;
   op_type               opcode;
   logic [LEN_W-1:0]     req_size;
   logic [START_W-1:0]   free_offset;

   modport source (output valid, opcode, req_size, free_offset, input ready);
   modport sink   (input valid, opcode, req_size, free_offset, output ready);
endinterface

### sv/ffha_rsp_if.sv
interface ffha_rsp_if;
   import ffha_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [START_W-1:0]   block_offset;
   status_type           status;

   modport source (output valid, block_offset, status, input ready);
   modport sink   (input valid, block_offset, status, output ready);
endinterface

### sv/ffha_ram.sv
module ffha_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

### sv/first_fit_heap_allocator.sv
// Sequencing: allocate scans the free table for the fit, shifts used entries to insert, then
//   updates or shifts out the free entry; free scans and shifts the used table, then scans and
//   shifts the free table to merge or insert. One transaction is in work at a time.
// Throughput: one table entry per cycle, set by the single read port of each table memory.
// Reset: synchronous; the cycle after reset writes the initial free chunk, then req is ready.
module first_fit_heap_allocator #(
   parameter int TABLE_ENTRIES = 1024
) (
   input  logic       clock,
   input  logic       reset,
   ffha_req_if.sink   req_chan,
   ffha_rsp_if.source rsp_chan
);
   import ffha_pkg::*;

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
   localparam int ENT_W = $bits(entry_type);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);
   localparam logic [CNT_W-1:0] ONE_CNT  = CNT_W'(1);

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_FIT, S_USED_INS, S_FREE_UPD, S_FREE_RM, S_FIND,
      S_USED_RM, S_POS, S_MERGE, S_FREE_INS, S_DONE
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   ptr_ff, ptr_in;
   logic               rv_ff, rv_in;
   logic [IDX_W-1:0]   ridx_ff, ridx_in;
   logic [CNT_W-1:0]   fcnt_ff, fcnt_in;
   logic [CNT_W-1:0]   ucnt_ff, ucnt_in;
   logic [LEN_W-1:0]   size_ff, size_in;
   logic [START_W-1:0] addr_ff, addr_in;
   logic [IDX_W-1:0]   hit_ff, hit_in;
   entry_type          hit_ent_ff, hit_ent_in;
   entry_type          prev_ff, prev_in;
   logic               prev_ok_ff, prev_ok_in;
   entry_type          next_ff, next_in;
   logic               next_ok_ff, next_ok_in;
   logic [IDX_W-1:0]   pos_ff, pos_in;
   logic [START_W-1:0] res_off_ff, res_off_in;
   status_type         res_status_ff, res_status_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [START_W-1:0] rsp_off_ff, rsp_off_in;
   status_type         rsp_status_ff, rsp_status_in;

   logic [IDX_W-1:0]   rd_addr;
   logic               fram_we, uram_we;
   logic [IDX_W-1:0]   fram_waddr, uram_waddr;
   entry_type          fram_wdata, uram_wdata;
   logic [ENT_W-1:0]   fram_rdata, uram_rdata;
   entry_type          frd, urd;
   logic [CNT_W-1:0]   ptr_dn;
   logic [LEN_W-1:0]   tail;
   logic               prev_touch, next_touch;

   ffha_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_ENTRIES)) u_free_ram (
      .clock (clock),
      .we    (fram_we),
      .waddr (fram_waddr),
      .wdata (fram_wdata),
      .raddr (rd_addr),
      .rdata (fram_rdata)
   );

   ffha_ram #(.WIDTH(ENT_W), .DEPTH(TABLE_ENTRIES)) u_used_ram (
      .clock (clock),
      .we    (uram_we),
      .waddr (uram_waddr),
      .wdata (uram_wdata),
      .raddr (rd_addr),
      .rdata (uram_rdata)
   );

   assign frd = entry_type'(fram_rdata);
   assign urd = entry_type'(uram_rdata);
   assign ptr_dn = ptr_ff - ONE_CNT;
   assign tail = hit_ent_ff.len - size_ff;
   assign prev_touch = prev_ok_ff &&
      (({1'b0, prev_ff.start} + prev_ff.len) == {1'b0, addr_ff});
   assign next_touch = next_ok_ff &&
      (({1'b0, addr_ff} + hit_ent_ff.len) == {1'b0, next_ff.start});

   assign req_chan.ready     = (state_ff == S_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.block_offset = rsp_off_ff;
   assign rsp_chan.status       = rsp_status_ff;

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      rv_in         = 1'b0;
      ridx_in       = ridx_ff;
      fcnt_in       = fcnt_ff;
      ucnt_in       = ucnt_ff;
      size_in       = size_ff;
      addr_in       = addr_ff;
      hit_in        = hit_ff;
      hit_ent_in    = hit_ent_ff;
      prev_in       = prev_ff;
      prev_ok_in    = prev_ok_ff;
      next_in       = next_ff;
      next_ok_in    = next_ok_ff;
      pos_in        = pos_ff;
      res_off_in    = res_off_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_off_in    = rsp_off_ff;
      rsp_status_in = rsp_status_ff;
      rd_addr       = '0;
      fram_we       = 1'b0;
      fram_waddr    = '0;
      fram_wdata    = '0;
      uram_we       = 1'b0;
      uram_waddr    = '0;
      uram_wdata    = '0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_INIT: begin
            fram_we    = 1'b1;
            fram_wdata = '{start: '0, len: LEN_W'(HEAP_BYTES)};
            state_in   = S_IDLE;
         end
         S_IDLE: begin
            ptr_in = '0;
            if (req_chan.valid) begin
               size_in    = req_chan.req_size;
               addr_in    = req_chan.free_offset;
               res_off_in = '0;
               if (req_chan.opcode == OP_FREE) begin
                  state_in = S_FIND;
               end else if (req_chan.req_size == '0) begin
                  res_status_in = ST_ZERO;
                  state_in      = S_DONE;
               end else begin
                  state_in = S_FIT;
               end
            end
         end
         S_FIT: begin
            if (ptr_ff < fcnt_ff) begin
               rd_addr = ptr_ff[IDX_W-1:0];
               ptr_in  = ptr_ff + ONE_CNT;
               rv_in   = 1'b1;
               ridx_in = ptr_ff[IDX_W-1:0];
            end
            if (rv_ff) begin
               if (frd.len >= size_ff) begin
                  hit_in     = ridx_ff;
                  hit_ent_in = frd;
                  rv_in      = 1'b0;
                  if (ucnt_ff >= FULL_CNT) begin
                     res_status_in = ST_FULL;
                     state_in      = S_DONE;
                  end else begin
                     ptr_in   = ucnt_ff;
                     state_in = S_USED_INS;
                  end
               end
            end else if (ptr_ff >= fcnt_ff) begin
               res_status_in = ST_NOFIT;
               state_in      = S_DONE;
            end
         end
         S_USED_INS: begin
            if (ptr_ff != '0) begin
               rd_addr = ptr_dn[IDX_W-1:0];
               ptr_in  = ptr_dn;
               rv_in   = 1'b1;
               ridx_in = ptr_dn[IDX_W-1:0];
            end
            if (rv_ff) begin
               uram_we    = 1'b1;
               uram_waddr = ridx_ff + IDX_W'(1);
               if (hit_ent_ff.start < urd.start) begin
                  uram_wdata = urd;
               end else begin
                  uram_wdata = '{start: hit_ent_ff.start, len: size_ff};
                  ucnt_in    = ucnt_ff + ONE_CNT;
                  rv_in      = 1'b0;
                  state_in   = S_FREE_UPD;
               end
            end else if (ptr_ff == '0) begin
               uram_we    = 1'b1;
               uram_waddr = '0;
               uram_wdata = '{start: hit_ent_ff.start, len: size_ff};
               ucnt_in    = ucnt_ff + ONE_CNT;
               state_in   = S_FREE_UPD;
            end
         end
         S_FREE_UPD: begin
            res_status_in = ST_OK;
            res_off_in    = hit_ent_ff.start;
            if (tail != '0) begin
               fram_we    = 1'b1;
               fram_waddr = hit_ff;
               fram_wdata = '{start: hit_ent_ff.start + size_ff[START_W-1:0], len: tail};
               state_in   = S_DONE;
            end else begin
               ptr_in   = CNT_W'(hit_ff) + ONE_CNT;
               state_in = S_FREE_RM;
            end
         end
         S_FREE_RM: begin
            if (ptr_ff < fcnt_ff) begin
               rd_addr = ptr_ff[IDX_W-1:0];
               ptr_in  = ptr_ff + ONE_CNT;
               rv_in   = 1'b1;
               ridx_in = ptr_ff[IDX_W-1:0];
            end
            if (rv_ff) begin
               fram_we    = 1'b1;
               fram_waddr = ridx_ff - IDX_W'(1);
               fram_wdata = frd;
            end else if (ptr_ff >= fcnt_ff) begin
               fcnt_in  = fcnt_ff - ONE_CNT;
               state_in = S_DONE;
            end
         end
         S_FIND: begin
            if (ptr_ff < ucnt_ff) begin
               rd_addr = ptr_ff[IDX_W-1:0];
               ptr_in  = ptr_ff + ONE_CNT;
               rv_in   = 1'b1;
               ridx_in = ptr_ff[IDX_W-1:0];
            end
            if (rv_ff) begin
               if (urd.start == addr_ff) begin
                  hit_ent_in = urd;
                  rv_in      = 1'b0;
                  if (fcnt_ff >= FULL_CNT) begin
                     res_status_in = ST_FULL;
                     state_in      = S_DONE;
                  end else begin
                     ptr_in   = CNT_W'(ridx_ff) + ONE_CNT;
                     state_in = S_USED_RM;
                  end
               end
            end else if (ptr_ff >= ucnt_ff) begin
               res_status_in = ST_UNKNOWN;
               state_in      = S_DONE;
            end
         end
         S_USED_RM: begin
            if (ptr_ff < ucnt_ff) begin
               rd_addr = ptr_ff[IDX_W-1:0];
               ptr_in  = ptr_ff + ONE_CNT;
               rv_in   = 1'b1;
               ridx_in = ptr_ff[IDX_W-1:0];
            end
            if (rv_ff) begin
               uram_we    = 1'b1;
               uram_waddr = ridx_ff - IDX_W'(1);
               uram_wdata = urd;
            end else if (ptr_ff >= ucnt_ff) begin
               ucnt_in    = ucnt_ff - ONE_CNT;
               ptr_in     = '0;
               rv_in      = 1'b0;
               prev_ok_in = 1'b0;
               state_in   = S_POS;
            end
         end
         S_POS: begin
            if (ptr_ff < fcnt_ff) begin
               rd_addr = ptr_ff[IDX_W-1:0];
               ptr_in  = ptr_ff + ONE_CNT;
               rv_in   = 1'b1;
               ridx_in = ptr_ff[IDX_W-1:0];
            end
            if (rv_ff) begin
               if (frd.start > addr_ff) begin
                  next_in    = frd;
                  next_ok_in = 1'b1;
                  pos_in     = ridx_ff;
                  rv_in      = 1'b0;
                  state_in   = S_MERGE;
               end else begin
                  prev_in    = frd;
                  prev_ok_in = 1'b1;
               end
            end else if (ptr_ff >= fcnt_ff) begin
               next_ok_in = 1'b0;
               pos_in     = fcnt_ff[IDX_W-1:0];
               state_in   = S_MERGE;
            end
         end
         S_MERGE: begin
            res_status_in = ST_OK;
            res_off_in    = addr_ff;
            if (prev_touch && next_touch) begin
               fram_we    = 1'b1;
               fram_waddr = pos_ff - IDX_W'(1);
               fram_wdata = '{start: prev_ff.start,
                              len: prev_ff.len + hit_ent_ff.len + next_ff.len};
               ptr_in     = CNT_W'(pos_ff) + ONE_CNT;
               state_in   = S_FREE_RM;
            end else if (prev_touch) begin
               fram_we    = 1'b1;
               fram_waddr = pos_ff - IDX_W'(1);
               fram_wdata = '{start: prev_ff.start, len: prev_ff.len + hit_ent_ff.len};
               state_in   = S_DONE;
            end else if (next_touch) begin
               fram_we    = 1'b1;
               fram_waddr = pos_ff;
               fram_wdata = '{start: addr_ff, len: hit_ent_ff.len + next_ff.len};
               state_in   = S_DONE;
            end else begin
               ptr_in   = fcnt_ff;
               state_in = S_FREE_INS;
            end
         end
         S_FREE_INS: begin
            if (ptr_ff != '0) begin
               rd_addr = ptr_dn[IDX_W-1:0];
               ptr_in  = ptr_dn;
               rv_in   = 1'b1;
               ridx_in = ptr_dn[IDX_W-1:0];
            end
            if (rv_ff) begin
               fram_we    = 1'b1;
               fram_waddr = ridx_ff + IDX_W'(1);
               if (addr_ff < frd.start) begin
                  fram_wdata = frd;
               end else begin
                  fram_wdata = '{start: addr_ff, len: hit_ent_ff.len};
                  fcnt_in    = fcnt_ff + ONE_CNT;
                  rv_in      = 1'b0;
                  state_in   = S_DONE;
               end
            end else if (ptr_ff == '0) begin
               fram_we    = 1'b1;
               fram_waddr = '0;
               fram_wdata = '{start: addr_ff, len: hit_ent_ff.len};
               fcnt_in    = fcnt_ff + ONE_CNT;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_off_in    = (res_status_ff == ST_OK) ? res_off_ff : '0;
               rsp_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         rv_ff        <= 1'b0;
         fcnt_ff      <= ONE_CNT;
         ucnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rv_ff        <= rv_in;
         fcnt_ff      <= fcnt_in;
         ucnt_ff      <= ucnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ptr_ff        <= ptr_in;
      ridx_ff       <= ridx_in;
      size_ff       <= size_in;
      addr_ff       <= addr_in;
      hit_ff        <= hit_in;
      hit_ent_ff    <= hit_ent_in;
      prev_ff       <= prev_in;
      prev_ok_ff    <= prev_ok_in;
      next_ff       <= next_in;
      next_ok_ff    <= next_ok_in;
      pos_ff        <= pos_in;
      res_off_ff    <= res_off_in;
      res_status_ff <= res_status_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_status_ff <= rsp_status_in;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      fcnt_ff <= FULL_CNT && ucnt_ff <= FULL_CNT)
      else $error("table count beyond depth");

   a_fwr_range: assert property (@(posedge clock) disable iff (reset)
      fram_we |-> CNT_W'(fram_waddr) <= fcnt_ff)
      else $error("free table write past count");

   a_uwr_range: assert property (@(posedge clock) disable iff (reset)
      uram_we |-> CNT_W'(uram_waddr) <= ucnt_ff)
      else $error("used table write past count");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != ST_OK |-> rsp_off_ff == '0)
      else $error("error transaction with nonzero offset");

endmodule
